FILE: sv/piecewise_cumulative_hazard_unit_defines.svh
// Assertion macros shared by the piecewise cumulative hazard unit.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef PIECEWISE_CUMULATIVE_HAZARD_UNIT_DEFINES_SVH
`define PIECEWISE_CUMULATIVE_HAZARD_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every clock edge outside reset.
`define PCH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pch assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define PCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pch assertion failed");
`else
`define PCH_ASSERT(lbl, clk, rst_n, prop)
`define PCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/pch_pkg.sv
// Package for the piecewise cumulative hazard unit: modes, state type, command struct.
// No dependencies; used by the controller, the datapath and the top level.
package pch_pkg;

    // Field widths fixed by the interface.
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 48;
    localparam int PROD_W  = 2 * VALUE_W;

    // Largest value of the cumulative hazard.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Breakpoint count after reset.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;

    // Cycles spent after the walk until the last term is accumulated.
    localparam int DRAIN_W = 1;
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = 1'b1;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD_BP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_RATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_bp;      // write breakpoint table
        logic load_rate;    // write rate table
        logic query_start;  // latch time and clear the accumulator
        logic issue;        // read one table entry pair this cycle
        logic issue_pair;   // entry read has a predecessor, so it closes an interval
    } t_dp_cmd;

endpackage

FILE: sv/pch_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module pch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pch_ctrl.sv
// Controller of the piecewise cumulative hazard unit: handshake, count register, table walk.
// Depends on pch_pkg and the assertion macros header.
`include "piecewise_cumulative_hazard_unit_defines.svh"
module pch_ctrl #(
    parameter int MAX_BREAKPOINTS = 64,
    localparam int AW = $clog2(MAX_BREAKPOINTS),
    localparam int CW = $clog2(MAX_BREAKPOINTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pch_pkg::MODE_W-1:0]    i_mode,
    input  logic                          i_cfg_we,
    input  logic [pch_pkg::COUNT_W-1:0]   i_cfg_wdata,
    input  logic                          i_found,
    output pch_pkg::t_dp_cmd              o_cmd,
    output logic [AW-1:0]                 o_rd_addr,
    output logic                          o_valid
);
    import pch_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [COUNT_W-1:0]    r_count;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_addr;
    logic [DRAIN_W-1:0]    r_drain;
    logic [CW-1:0]         cnt_clamped;
    logic                  accept;
    t_dp_cmd               cmd;

    // Breakpoint count limited to the table depth.
    assign cnt_clamped = (32'(r_count) > 32'(MAX_BREAKPOINTS)) ?
                         CW'(MAX_BREAKPOINTS) : CW'(r_count);

    assign accept = start && (r_state == ST_IDLE);

    // Command and status outputs.
    always_comb begin
        cmd = '0;
        if (accept) begin
            case (i_mode)
                MODE_LOAD_BP:   cmd.load_bp     = 1'b1;
                MODE_LOAD_RATE: cmd.load_rate   = 1'b1;
                MODE_QUERY:     cmd.query_start = 1'b1;
                default:        cmd             = '0;
            endcase
        end
        cmd.issue      = (r_state == ST_WALK) && (r_addr < r_cnt) && !i_found;
        cmd.issue_pair = (r_addr != '0);
        busy           = (r_state != ST_IDLE);
        o_valid        = (r_state == ST_FINISH);
    end

    assign o_cmd     = cmd;
    assign o_rd_addr = r_addr[AW-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cmd.query_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!cmd.issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain == DRAIN_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State, count register, walk address and drain counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= COUNT_RESET;
            r_cnt   <= '0;
            r_addr  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (cmd.query_start) begin
                r_cnt  <= cnt_clamped;
                r_addr <= '0;
            end else if (cmd.issue) begin
                r_addr <= r_addr + CW'(1);
            end
            if (r_state == ST_DRAIN) begin
                r_drain <= r_drain + DRAIN_W'(1);
            end else begin
                r_drain <= '0;
            end
        end
    end

    `PCH_ASSERT(a_load_idle, i_clk, i_rst_n, (cmd.load_bp || cmd.load_rate) |-> !busy)
    `PCH_ASSERT_NEXT(a_query_walk, i_clk, i_rst_n, cmd.query_start, r_state == ST_WALK)
    `PCH_ASSERT(a_finish_drain, i_clk, i_rst_n, o_valid |-> $past(r_state) == ST_DRAIN)
    `PCH_ASSERT(a_addr_bound, i_clk, i_rst_n, (r_state == ST_WALK) |-> (r_addr <= r_cnt))

endmodule

FILE: sv/pch_datapath.sv
// Datapath of the piecewise cumulative hazard unit: tables, interval classify,
// multiplier stage and saturating accumulator. Depends on pch_pkg, pch_ram and the macros header.
`include "piecewise_cumulative_hazard_unit_defines.svh"
module pch_datapath #(
    parameter int MAX_BREAKPOINTS = 64,
    parameter int FRACTION_BITS   = 16,
    localparam int AW = $clog2(MAX_BREAKPOINTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pch_pkg::t_dp_cmd              i_cmd,
    input  logic [AW-1:0]                 i_rd_addr,
    input  logic [pch_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [pch_pkg::VALUE_W-1:0]   i_entry_value,
    input  logic [pch_pkg::VALUE_W-1:0]   i_survival_time,
    output logic                          o_found,
    output logic [pch_pkg::SUM_W-1:0]     o_cumulative_hazard,
    output logic [pch_pkg::VALUE_W-1:0]   o_hazard_at_time,
    output logic                          o_saturated
);
    import pch_pkg::*;

    logic                 index_ok;
    logic [AW-1:0]        waddr;
    logic [VALUE_W-1:0]   bp_rd;
    logic [VALUE_W-1:0]   rate_rd;

    logic [VALUE_W-1:0]   r_time;
    logic                 r_rd_vld;
    logic                 r_rd_pair;
    logic [VALUE_W-1:0]   r_prev_bp;
    logic [VALUE_W-1:0]   r_prev_rate;

    logic                 act;
    logic                 hit;
    logic                 above;
    logic [VALUE_W-1:0]   width;

    logic                 r_found;
    logic [VALUE_W-1:0]   r_rate_out;
    logic                 r_mul_vld;
    logic [VALUE_W-1:0]   r_mul_rate;
    logic [VALUE_W-1:0]   r_mul_width;
    logic                 r_prod_vld;
    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    term;
    logic [PROD_W:0]      sum_ext;
    logic [SUM_W-1:0]     r_acc;
    logic                 r_sat;

    // Table writes; slots beyond the table depth are dropped.
    assign index_ok = (32'(i_entry_index) < 32'(MAX_BREAKPOINTS));
    assign waddr    = AW'(i_entry_index);

    pch_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_BREAKPOINTS)) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_bp && index_ok),
        .i_waddr (waddr),
        .i_wdata (i_entry_value),
        .i_raddr (i_rd_addr),
        .o_rdata (bp_rd)
    );

    pch_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_BREAKPOINTS)) u_rate_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_rate && index_ok),
        .i_waddr (waddr),
        .i_wdata (i_entry_value),
        .i_raddr (i_rd_addr),
        .o_rdata (rate_rd)
    );

    // Interval classify: the previous entry opens the interval, the current one closes it.
    always_comb begin
        act   = r_rd_vld && r_rd_pair && !r_found;
        hit   = act && (r_time > r_prev_bp) && (r_time <= bp_rd);
        above = act && (r_time > bp_rd);
        if (hit) begin
            width = r_time - r_prev_bp;
        end else if (above && (bp_rd > r_prev_bp)) begin
            width = bp_rd - r_prev_bp;
        end else begin
            width = '0;
        end
    end

    // Scaled product and saturating sum.
    assign term    = r_prod >> FRACTION_BITS;
    assign sum_ext = (PROD_W + 1)'(r_acc) + (PROD_W + 1)'(term);

    // Payload registers of the read and multiply stages.
    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_time <= i_survival_time;
        end
        if (r_rd_vld) begin
            r_prev_bp   <= bp_rd;
            r_prev_rate <= rate_rd;
        end
        r_mul_rate  <= r_prev_rate;
        r_mul_width <= width;
        r_prod      <= PROD_W'(r_mul_rate) * PROD_W'(r_mul_width);
    end

    // Stage valids, interval found flag and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_pair  <= 1'b0;
            r_mul_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_found    <= 1'b0;
            r_rate_out <= '0;
            r_acc      <= '0;
            r_sat      <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.issue;
            r_rd_pair  <= i_cmd.issue_pair;
            r_mul_vld  <= act;
            r_prod_vld <= r_mul_vld;
            if (i_cmd.query_start) begin
                r_found    <= 1'b0;
                r_rate_out <= '0;
                r_acc      <= '0;
                r_sat      <= 1'b0;
            end else begin
                if (hit) begin
                    r_found    <= 1'b1;
                    r_rate_out <= r_prev_rate;
                end
                if (r_prod_vld) begin
                    if (sum_ext > (PROD_W + 1)'(SUM_MAX)) begin
                        r_acc <= SUM_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_acc <= sum_ext[SUM_W-1:0];
                    end
                end
            end
        end
    end

    assign o_found             = r_found;
    assign o_cumulative_hazard = r_acc;
    assign o_hazard_at_time    = r_rate_out;
    assign o_saturated         = r_sat;

    `PCH_ASSERT(a_sat_max, i_clk, i_rst_n, r_sat |-> (r_acc == SUM_MAX))
    `PCH_ASSERT(a_rate_found, i_clk, i_rst_n, (r_rate_out != '0) |-> r_found)
    `PCH_ASSERT(a_found_clear, i_clk, i_rst_n, $fell(r_found) |-> $past(i_cmd.query_start))

endmodule

FILE: sv/piecewise_cumulative_hazard_unit.sv
// Top level of the piecewise cumulative hazard unit.
// Depends on pch_pkg, pch_ctrl and pch_datapath.
//
// Usage: an item is transferred at a rising edge with start high and busy low.
// Mode 0 writes entry_value into breakpoint slot entry_index, mode 1 into the
// rate slot; both give no result and leave busy low. Mode 2 queries survival_time:
// the unit walks the breakpoint table one entry per cycle through a single read
// port of each table, one multiplier and one accumulator. With N the breakpoint
// count (limited to MAX_BREAKPOINTS), the walk reads at most N entries and ends
// early once the interval that holds the time is found. Busy stays high until the
// result cycle is over. The result transfers with o_valid high for exactly one
// cycle; the receiver cannot stall it. The breakpoint count register is written
// through i_cfg_we/i_cfg_wdata; the user must write it only while the unit is
// idle, since the unit itself does not enforce this. Reset sets the count to two
// and clears all control state; the table contents stay undefined until loaded.
module piecewise_cumulative_hazard_unit #(
    parameter int MAX_BREAKPOINTS = 64,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pch_pkg::MODE_W-1:0]    i_mode,
    input  logic [pch_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [pch_pkg::VALUE_W-1:0]   i_entry_value,
    input  logic [pch_pkg::VALUE_W-1:0]   i_survival_time,
    input  logic                          i_cfg_we,
    input  logic [pch_pkg::COUNT_W-1:0]   i_cfg_wdata,
    output logic                          o_valid,
    output logic [pch_pkg::SUM_W-1:0]     o_cumulative_hazard,
    output logic [pch_pkg::VALUE_W-1:0]   o_hazard_at_time,
    output logic                          o_saturated
);
    import pch_pkg::*;

    localparam int AW = $clog2(MAX_BREAKPOINTS);

    t_dp_cmd        cmd;
    logic [AW-1:0]  rd_addr;
    logic           found;

    // Sequencer: handshake, count register and walk addresses.
    pch_ctrl #(.MAX_BREAKPOINTS(MAX_BREAKPOINTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_found     (found),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_valid     (o_valid)
    );

    // Tables and arithmetic.
    pch_datapath #(
        .MAX_BREAKPOINTS (MAX_BREAKPOINTS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_rd_addr           (rd_addr),
        .i_entry_index       (i_entry_index),
        .i_entry_value       (i_entry_value),
        .i_survival_time     (i_survival_time),
        .o_found             (found),
        .o_cumulative_hazard (o_cumulative_hazard),
        .o_hazard_at_time    (o_hazard_at_time),
        .o_saturated         (o_saturated)
    );

endmodule

FILE: bench/piecewise_cumulative_hazard_unit_test.sv
// Self-checking testbench for the piecewise cumulative hazard unit.
// Depends on pch_pkg and the unit's RTL; every query result is predicted here and compared.
module piecewise_cumulative_hazard_unit_test;
    import pch_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int FRAC_BITS      = 16;
    localparam int CLOCK_PERIOD   = 20;
    localparam int RESET_CYCLES   = 9;
    // Exceeds the longest query, a walk of the full table, with margin.
    localparam int SETTLE_CYCLES  = 80;
    localparam int DRAIN_LIMIT    = 1000;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int MAX_REPORTS    = 100;
    localparam int COUNT_TOP      = (1 << COUNT_W) - 1;

    // Mode 3 has no function; the unit must ignore it.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0]   hazard;
        logic [VALUE_W-1:0] rate;
        logic               saturated;
    } t_hazard_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [MODE_W-1:0]    i_mode;
    logic [INDEX_W-1:0]   i_entry_index;
    logic [VALUE_W-1:0]   i_entry_value;
    logic [VALUE_W-1:0]   i_survival_time;
    logic                 i_cfg_we;
    logic [COUNT_W-1:0]   i_cfg_wdata;
    logic                 o_valid;
    logic [SUM_W-1:0]     o_cumulative_hazard;
    logic [VALUE_W-1:0]   o_hazard_at_time;
    logic                 o_saturated;

    // Shadow of the unit's tables and count, updated on accepted table loads and count writes.
    logic [VALUE_W-1:0]   model_bp [TABLE_DEPTH];
    logic [VALUE_W-1:0]   model_rate [TABLE_DEPTH];
    logic [COUNT_W-1:0]   model_count;
    t_hazard_result       expected_hazards [$];

    // Stimulus side view of the breakpoints and count, used to aim query times.
    logic [VALUE_W-1:0]   plan_bp [TABLE_DEPTH];
    logic [COUNT_W-1:0]   plan_count;
    int unsigned          sender_idle_pct;

    int unsigned          items_sent;
    int unsigned          error_count;
    int unsigned          results_checked;
    int unsigned          saturated_predicted;
    int unsigned          zero_rate_predicted;
    int unsigned          loads_seen;
    int unsigned          cfg_writes;

    piecewise_cumulative_hazard_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_mode              (i_mode),
        .i_entry_index       (i_entry_index),
        .i_entry_value       (i_entry_value),
        .i_survival_time     (i_survival_time),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_valid             (o_valid),
        .o_cumulative_hazard (o_cumulative_hazard),
        .o_hazard_at_time    (o_hazard_at_time),
        .o_saturated         (o_saturated)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLOCK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Walks the intervals below the time and sums rate times width, clipping the sum.
    function automatic t_hazard_result predict_hazard(input logic [VALUE_W-1:0] t);
        t_hazard_result     res;
        int unsigned        n;
        logic [63:0]        acc;
        logic [63:0]        term;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] r;
        logic [VALUE_W-1:0] w;
        bit                 found;
        res   = '0;
        acc   = '0;
        found = 1'b0;
        n = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
        for (int j = 0; j + 1 < n && !found; j++) begin
            lo   = model_bp[j];
            hi   = model_bp[j + 1];
            r    = model_rate[j];
            term = '0;
            if (t > lo && t <= hi) begin
                // The interval holding the time contributes only up to the time.
                term     = ({32'b0, r} * {32'b0, VALUE_W'(t - lo)}) >> FRAC_BITS;
                res.rate = r;
                found    = 1'b1;
            end else if (t > hi) begin
                // A descending interval has no width.
                w    = (hi > lo) ? hi - lo : '0;
                term = ({32'b0, r} * {32'b0, w}) >> FRAC_BITS;
            end
            if (term > {16'b0, SUM_MAX} - acc) begin
                acc           = {16'b0, SUM_MAX};
                res.saturated = 1'b1;
            end else begin
                acc = acc + term;
            end
        end
        res.hazard = acc[SUM_W-1:0];
        return res;
    endfunction

    // Checks each result transfer, then tracks item transfers and count writes.
    always @(posedge i_clk) begin : scoreboard
        t_hazard_result got;
        t_hazard_result want;
        if (!i_rst_n) begin
            model_count = COUNT_RESET;
        end else begin
            if (o_valid) begin
                got = {o_cumulative_hazard, o_hazard_at_time, o_saturated};
                if (expected_hazards.size() == 0) begin
                    report_mismatch("result with no query waiting", '0, 64'(got.hazard));
                end else begin
                    want = expected_hazards.pop_front();
                    results_checked++;
                    if (got.hazard !== want.hazard)
                        report_mismatch("cumulative hazard", 64'(want.hazard),
                                        64'(got.hazard));
                    if (got.rate !== want.rate)
                        report_mismatch("hazard at time", 64'(want.rate), 64'(got.rate));
                    if (got.saturated !== want.saturated)
                        report_mismatch("saturated flag", 64'(want.saturated),
                                        64'(got.saturated));
                end
            end
            if (i_cfg_we) begin
                model_count = i_cfg_wdata;
                cfg_writes++;
            end
            if (start && !busy) begin
                case (i_mode)
                    MODE_LOAD_BP: begin
                        model_bp[i_entry_index] = i_entry_value;
                        loads_seen++;
                    end
                    MODE_LOAD_RATE: begin
                        model_rate[i_entry_index] = i_entry_value;
                        loads_seen++;
                    end
                    MODE_QUERY: begin
                        want = predict_hazard(i_survival_time);
                        expected_hazards.push_back(want);
                        if (want.saturated)
                            saturated_predicted++;
                        if (want.rate == '0)
                            zero_rate_predicted++;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Sends one item, idling the port at random first, and returns after its transfer.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] index,
                             input logic [VALUE_W-1:0] value, input logic [VALUE_W-1:0] t);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_mode          <= mode;
        i_entry_index   <= index;
        i_entry_value   <= value;
        i_survival_time <= t;
        if (mode == MODE_LOAD_BP)
            plan_bp[index] = value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    // Writes the breakpoint count once every query has returned and the unit has settled.
    task automatic write_breakpoint_count(input logic [COUNT_W-1:0] count);
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_hazards.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        plan_count = count;
    endtask

    // Rates mix the extremes, small values and full-width values.
    function automatic logic [VALUE_W-1:0] random_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Loads n ascending breakpoints with random spacing and a rate for each slot.
    task automatic load_ascending_table(input int unsigned n);
        logic [VALUE_W-1:0] point;
        logic [VALUE_W-1:0] limit;
        logic [VALUE_W-1:0] step_max;
        point    = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(0, 32'h0010_0000);
        limit    = (32'hFFFF_FFFF - point) / n;
        step_max = ($urandom_range(0, 3) == 0) ? limit : $urandom_range(1, 32'h0008_0000);
        if (step_max > limit)
            step_max = limit;
        if (step_max == '0)
            step_max = 1;
        for (int j = 0; j < n; j++) begin
            send_item(MODE_LOAD_BP, INDEX_W'(j), point, $urandom);
            send_item(MODE_LOAD_RATE, INDEX_W'(j), random_rate(), $urandom);
            point = point + $urandom_range(1, step_max);
        end
    endtask

    // Aims a query time at an interval edge, inside an interval, or anywhere.
    function automatic logic [VALUE_W-1:0] pick_query_time();
        int unsigned        n;
        int unsigned        k;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        n = (plan_count > TABLE_DEPTH) ? TABLE_DEPTH : plan_count;
        if (n < 2)
            return $urandom;
        k  = $urandom_range(0, n - 2);
        lo = plan_bp[k];
        hi = plan_bp[k + 1];
        case ($urandom_range(0, 7))
            0: return lo;
            1: return lo + 1;
            2: return lo - 1;
            3: return hi;
            4, 5: return (hi > lo) ? lo + $urandom_range(0, hi - lo) : $urandom;
            6: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return $urandom;
        endcase
    endfunction

    // Unused modes and stray table writes that break the ascending order.
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_item(MODE_UNUSED, INDEX_W'($urandom), $urandom, $urandom);
            1: send_item(MODE_LOAD_BP, INDEX_W'($urandom), $urandom, $urandom);
            default: send_item(MODE_LOAD_RATE, INDEX_W'($urandom), random_rate(), $urandom);
        endcase
    endtask

    // Every slot of both tables is written before any query can read it.
    task automatic test_fill_tables();
        load_ascending_table(TABLE_DEPTH);
    endtask

    // With the count left at its reset value, probes times around the one interval.
    task automatic test_interval_edges();
        logic [VALUE_W-1:0] probe [6];
        probe = '{32'h0000_0000, 32'h0001_8000, 32'h0001_8001,
                  32'h0004_0000, 32'h0004_0001, 32'hFFFF_FFFF};
        send_item(MODE_LOAD_BP, INDEX_W'(0), 32'h0001_8000, '0);
        send_item(MODE_LOAD_BP, INDEX_W'(1), 32'h0004_0000, '1);
        send_item(MODE_LOAD_RATE, INDEX_W'(0), '1, '0);
        foreach (probe[i])
            send_item(MODE_QUERY, '1, '0, probe[i]);
    endtask

    // An item with the unused mode must give no result.
    task automatic test_unused_mode();
        send_item(MODE_UNUSED, '1, '1, '1);
        send_item(MODE_QUERY, '0, '1, 32'h0002_0000);
    endtask

    // An interval whose end lies below its start adds nothing when passed.
    task automatic test_descending_breakpoints();
        write_breakpoint_count(COUNT_W'(3));
        send_item(MODE_LOAD_BP, INDEX_W'(0), 32'h0010_0000, $urandom);
        send_item(MODE_LOAD_BP, INDEX_W'(1), 32'h0008_0000, $urandom);
        send_item(MODE_LOAD_BP, INDEX_W'(2), 32'h0020_0000, $urandom);
        send_item(MODE_QUERY, INDEX_W'($urandom), $urandom, 32'h0030_0000);
        send_item(MODE_QUERY, INDEX_W'($urandom), $urandom, 32'h000C_0000);
    endtask

    // Two near-full-range intervals at the top rate overflow the sum.
    task automatic test_saturation();
        write_breakpoint_count(COUNT_W'(4));
        send_item(MODE_LOAD_BP, INDEX_W'(0), 32'h0000_0000, $urandom);
        send_item(MODE_LOAD_BP, INDEX_W'(1), 32'hFFFF_FFFE, $urandom);
        send_item(MODE_LOAD_BP, INDEX_W'(2), 32'h0000_0001, $urandom);
        send_item(MODE_LOAD_BP, INDEX_W'(3), 32'hFFFF_FFFF, $urandom);
        send_item(MODE_LOAD_RATE, INDEX_W'(0), '1, $urandom);
        send_item(MODE_LOAD_RATE, INDEX_W'(2), '1, $urandom);
        send_item(MODE_QUERY, INDEX_W'($urandom), $urandom, 32'hFFFF_FFFF);
    endtask

    // Counts with no interval, the full table, and beyond the table size.
    task automatic test_count_extremes();
        logic [COUNT_W-1:0] counts [4];
        counts = '{COUNT_W'(0), COUNT_W'(1), COUNT_W'(TABLE_DEPTH), COUNT_W'(COUNT_TOP)};
        foreach (counts[i]) begin
            write_breakpoint_count(counts[i]);
            send_item(MODE_QUERY, INDEX_W'($urandom), $urandom, '1);
        end
    endtask

    // Segments of count write, ascending table and aimed queries, with some noise.
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned item_goal);
        int unsigned        phase_start;
        int unsigned        n;
        int unsigned        queries;
        logic [COUNT_W-1:0] count;
        sender_idle_pct = idle_pct;
        phase_start     = items_sent;
        while (items_sent - phase_start < item_goal) begin
            // Small counts dominate to keep the walks short.
            case ($urandom_range(0, 19))
                0: count = COUNT_W'($urandom_range(0, 1));
                1: count = COUNT_W'(TABLE_DEPTH);
                2: count = COUNT_W'($urandom_range(TABLE_DEPTH + 1, COUNT_TOP));
                3, 4: count = COUNT_W'($urandom_range(13, TABLE_DEPTH - 1));
                default: count = COUNT_W'($urandom_range(2, 12));
            endcase
            write_breakpoint_count(count);
            n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            if (n >= 2 && $urandom_range(0, 9) < 7)
                load_ascending_table(n);
            queries = $urandom_range(4, 16);
            repeat (queries) begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                send_item(MODE_QUERY, INDEX_W'($urandom), $urandom, pick_query_time());
            end
        end
    endtask

    // Reset, the directed tests, three random phases, then the final check.
    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_mode          <= MODE_LOAD_BP;
        i_entry_index   <= '0;
        i_entry_value   <= '0;
        i_survival_time <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        plan_count          = COUNT_RESET;
        sender_idle_pct     = 33;
        items_sent          = 0;
        error_count         = 0;
        results_checked     = 0;
        saturated_predicted = 0;
        zero_rate_predicted = 0;
        loads_seen          = 0;
        cfg_writes          = 0;
        foreach (model_bp[i]) begin
            model_bp[i]   = '0;
            model_rate[i] = '0;
            plan_bp[i]    = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_tables();
        test_interval_edges();
        test_unused_mode();
        test_descending_breakpoints();
        test_saturation();
        test_count_extremes();
        test_random_traffic(33, 550);
        test_random_traffic(78, 550);
        test_random_traffic(0, 550);

        // Let the last query return, then allow stray results to show up.
        start <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && expected_hazards.size() != 0; w++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_hazards.size() != 0)
            report_mismatch("query results never arrived", '0, 64'(expected_hazards.size()));

        $display("Checked %0d query results (%0d saturated, %0d with zero rate).",
                 results_checked, saturated_predicted, zero_rate_predicted);
        $display("Sent %0d items including %0d table loads, with %0d breakpoint count writes.",
                 items_sent, loads_seen, cfg_writes);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Ends a run that hangs.
    initial begin
        #(CLOCK_PERIOD * TIMEOUT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/pch_pkg.sv
sv/pch_ram.sv
sv/pch_ctrl.sv
sv/pch_datapath.sv
sv/piecewise_cumulative_hazard_unit.sv
bench/piecewise_cumulative_hazard_unit_test.sv
